// ----- hdl/siphash_bucket_index_unit_defines.svh -----
// Assertion macros shared by the SipHash bucket index unit.
`ifndef SIPHASH_BUCKET_INDEX_UNIT_DEFINES_SVH
`define SIPHASH_BUCKET_INDEX_UNIT_DEFINES_SVH

// Same-cycle implication, checked on i_clk and masked while i_rst_n is low.
`define SBI_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and masked while i_rst_n is low.
`define SBI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sbi_pkg.sv -----
// Types, constants and the SipRound function of the SipHash bucket index unit.
`default_nettype none

package sbi_pkg;

    localparam logic [63:0] SIP_KEY   = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_INIT0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_INIT1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_INIT2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_INIT3 = 64'h7465646279746573;
    localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;

    localparam logic [63:0] LANE0_RESET = SIP_KEY ^ SIP_INIT0;
    localparam logic [63:0] LANE1_RESET = SIP_KEY ^ SIP_INIT1;
    localparam logic [63:0] LANE2_RESET = SIP_KEY ^ SIP_INIT2;
    localparam logic [63:0] LANE3_RESET = SIP_KEY ^ SIP_INIT3;

    localparam logic [31:0] BUCKET_COUNT_RESET = 32'd16;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_lanes;

    // Commands from the sequencer to the lane datapath.
    typedef struct packed {
        logic init;
        logic round;
        logic xor_v3;
        logic xor_fin;
        logic xor_v0;
    } t_core_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_TAIL,
        ST_FINAL,
        ST_HASH,
        ST_MOD,
        ST_DONE
    } t_state;

    // One SipRound over all four lanes.
    function automatic t_lanes lane_round(input t_lanes a);
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
        t_lanes r;
        v0 = a.v0 + a.v1;
        v1 = {a.v1[50:0], a.v1[63:51]} ^ v0;
        v0 = {v0[31:0], v0[63:32]};
        v2 = a.v2 + a.v3;
        v3 = {a.v3[47:0], a.v3[63:48]} ^ v2;
        v0 = v0 + v3;
        v3 = {v3[42:0], v3[63:43]} ^ v0;
        v2 = v2 + v1;
        v1 = {v1[46:0], v1[63:47]} ^ v2;
        v2 = {v2[31:0], v2[63:32]};
        r.v0 = v0;
        r.v1 = v1;
        r.v2 = v2;
        r.v3 = v3;
        return r;
    endfunction

    // Keeps the low count bytes of a word.
    function automatic logic [63:0] tail_mask(input logic [2:0] count);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (3'(b) < count) begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sbi_req_if.sv -----
// Request channel carrying one key word.
`default_nettype none

interface sbi_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last_word;

    modport source (output valid, output message_word, output byte_count,
                    output last_word, input ready);
    modport sink (input valid, input message_word, input byte_count,
                  input last_word, output ready);
endinterface

`default_nettype wire

// ----- hdl/sbi_rsp_if.sv -----
// Response channel carrying the hash and the bucket index.
`default_nettype none

interface sbi_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_digest;
    logic [31:0] bucket_index;

    modport source (output valid, output hash_digest, output bucket_index, input ready);
    modport sink (input valid, input hash_digest, input bucket_index, output ready);
endinterface

`default_nettype wire

// ----- hdl/siphash_bucket_index_unit.sv -----
// Top level of the SipHash-2-4 bucket index unit: sequencer, config and result register.
//
// Usage. Keys arrive on i_req as little-endian 64-bit words (message_word,
// byte_count, last_word); a request is taken when valid and ready are both high.
// Every word that is not last is treated as eight full bytes. The word marked
// last may carry zero to eight bytes; counts above eight count as eight.
// Each word costs two SipRounds on the shared round datapath, one round per
// cycle; a full word that is not last lets the next word in during its second round.
// The last word adds the length tail (two more rounds when the word is full),
// four finalization rounds, a state that captures the hash and starts the
// bit-serial remainder unit, the remainder itself and a load of the result
// register; no new request is taken until the result is loaded.
// o_rsp carries hash_digest and bucket_index = hash mod bucket_count, or zero
// when bucket_count is zero. The result sits in an output register, so the
// unit takes the next key while it waits; if the receiver still stalls when
// the next result is ready, the unit holds that result and stays busy.
// bucket_count is written through i_cfg_wr_en/i_cfg_wr_data; the user must do so only
// while idle, as the unit does not enforce it. Reset (synchronous, active low) restores
// the lanes, clears the length and the output valid flag, and sets bucket_count to 16.
`default_nettype none

module siphash_bucket_index_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    sbi_req_if.sink     i_req,
    sbi_rsp_if.source   o_rsp
);

    sbi_pkg::t_state      r_state;
    sbi_pkg::t_state      n_state;
    logic [1:0]           r_round;
    logic [1:0]           n_round;
    logic [63:0]          r_msg;
    logic [63:0]          n_msg;
    logic [7:0]           r_len;
    logic [7:0]           n_len;
    logic                 r_last;
    logic                 n_last;
    logic [31:0]          r_bucket_count;
    logic [63:0]          r_hash;
    logic                 r_out_valid;
    logic [63:0]          r_out_hash;
    logic [31:0]          r_out_index;

    sbi_pkg::t_core_ctrl  w_core_ctrl;
    sbi_pkg::t_mod_status w_mod_status;
    logic [63:0]          w_core_hash;
    logic [31:0]          w_mod_rem;
    logic                 w_mod_start;
    logic                 w_out_load;
    logic                 w_ready;
    logic                 w_accept;
    logic                 w_full;
    logic [7:0]           w_len_acc;
    logic [63:0]          w_tail;
    logic                 w_out_free;

    // A word is full when it is not last or claims eight or more bytes.
    assign w_full    = !i_req.last_word || (i_req.byte_count >= 4'd8);
    assign w_len_acc = r_len + (w_full ? 8'd8 : {5'd0, i_req.byte_count[2:0]});
    assign w_tail    = (i_req.message_word & sbi_pkg::tail_mask(i_req.byte_count[2:0]))
                     | {w_len_acc, 56'd0};
    assign w_accept  = w_ready && i_req.valid;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_msg       = r_msg;
        n_len       = r_len;
        n_last      = r_last;
        w_core_ctrl = '0;
        w_mod_start = 1'b0;
        w_out_load  = 1'b0;
        w_ready     = 1'b0;

        case (r_state)
            sbi_pkg::ST_IDLE: begin
                w_ready = 1'b1;
            end
            sbi_pkg::ST_ABSORB: begin
                // Message xor into lane three before the first round, into lane
                // zero after the second.
                w_core_ctrl.round  = 1'b1;
                w_core_ctrl.xor_v3 = (r_round == 2'd0);
                w_core_ctrl.xor_v0 = (r_round == 2'd1);
                n_round = r_round + 2'd1;
                if (r_round == 2'd1) begin
                    n_round = 2'd0;
                    if (r_last) begin
                        // A full last word is followed by a tail of length only.
                        n_state = sbi_pkg::ST_TAIL;
                        n_msg   = {r_len, 56'd0};
                    end else begin
                        n_state = sbi_pkg::ST_IDLE;
                        w_ready = 1'b1;
                    end
                end
            end
            sbi_pkg::ST_TAIL: begin
                w_core_ctrl.round  = 1'b1;
                w_core_ctrl.xor_v3 = (r_round == 2'd0);
                w_core_ctrl.xor_v0 = (r_round == 2'd1);
                n_round = r_round + 2'd1;
                if (r_round == 2'd1) begin
                    n_round = 2'd0;
                    n_state = sbi_pkg::ST_FINAL;
                end
            end
            sbi_pkg::ST_FINAL: begin
                // The finalization constant enters lane two ahead of round one.
                w_core_ctrl.round   = 1'b1;
                w_core_ctrl.xor_fin = (r_round == 2'd0);
                n_round = r_round + 2'd1;
                if (r_round == 2'd3) begin
                    n_state = sbi_pkg::ST_HASH;
                end
            end
            sbi_pkg::ST_HASH: begin
                // Capture the hash, start the remainder and restore the lanes.
                w_core_ctrl.init = 1'b1;
                w_mod_start      = 1'b1;
                n_len            = 8'd0;
                n_state          = sbi_pkg::ST_MOD;
            end
            sbi_pkg::ST_MOD: begin
                if (w_mod_status.done) begin
                    if (w_out_free) begin
                        w_out_load = 1'b1;
                        n_state    = sbi_pkg::ST_IDLE;
                    end else begin
                        n_state = sbi_pkg::ST_DONE;
                    end
                end
            end
            sbi_pkg::ST_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = sbi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sbi_pkg::ST_IDLE;
            end
        endcase

        if (w_accept) begin
            n_last  = i_req.last_word;
            n_len   = w_len_acc;
            n_round = 2'd0;
            if (w_full) begin
                n_state = sbi_pkg::ST_ABSORB;
                n_msg   = i_req.message_word;
            end else begin
                n_state = sbi_pkg::ST_TAIL;
                n_msg   = w_tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= sbi_pkg::ST_IDLE;
            r_round        <= 2'd0;
            r_len          <= 8'd0;
            r_last         <= 1'b0;
            r_bucket_count <= sbi_pkg::BUCKET_COUNT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_len   <= n_len;
            r_last  <= n_last;
            if (i_cfg_wr_en) begin
                r_bucket_count <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg <= n_msg;
        if (w_mod_start) begin
            r_hash <= w_core_hash;
        end
        if (w_out_load) begin
            r_out_hash  <= r_hash;
            r_out_index <= w_mod_rem;
        end
    end

    sbi_sip_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_core_ctrl),
        .i_msg   (r_msg),
        .o_hash  (w_core_hash)
    );

    sbi_mod_unit u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_mod_start),
        .i_dividend  (w_core_hash),
        .i_divisor   (r_bucket_count),
        .o_status    (w_mod_status),
        .o_remainder (w_mod_rem)
    );

    assign i_req.ready        = w_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hash_digest  = r_out_hash;
    assign o_rsp.bucket_index = r_out_index;

`include "siphash_bucket_index_unit_defines.svh"

    // Every accepted word starts round work on the shared datapath.
    `SBI_ASSERT_NEXT(a_accept_starts_work, w_accept, r_state != sbi_pkg::ST_IDLE, "accept left unit idle")
    // A word that is not last always runs two absorb rounds.
    `SBI_ASSERT_NEXT(a_middle_word_absorbs, w_accept && !i_req.last_word, r_state == sbi_pkg::ST_ABSORB, "middle word skipped absorb")
    // The remainder unit works only while the sequencer waits for it.
    `SBI_ASSERT_IMPLIES(a_mod_only_in_mod, w_mod_status.busy || w_mod_status.done, r_state == sbi_pkg::ST_MOD, "remainder unit active outside wait")
    // Loading a result never overwrites one the receiver has not taken.
    `SBI_ASSERT_IMPLIES(a_no_result_overwrite, w_out_load, !r_out_valid || o_rsp.ready, "result overwritten")

endmodule

`default_nettype wire

// ----- hdl/sbi_sip_core.sv -----
// Lane registers and shared SipRound datapath: one round per cycle on command.
`default_nettype none

module sbi_sip_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbi_pkg::t_core_ctrl i_ctrl,
    input  logic [63:0]         i_msg,
    output logic [63:0]         o_hash
);

    sbi_pkg::t_lanes r_lanes;
    sbi_pkg::t_lanes n_lanes;
    sbi_pkg::t_lanes w_round_in;
    sbi_pkg::t_lanes w_round_out;

    always_comb begin
        w_round_in = r_lanes;
        if (i_ctrl.xor_v3) begin
            w_round_in.v3 = r_lanes.v3 ^ i_msg;
        end
        if (i_ctrl.xor_fin) begin
            w_round_in.v2 = r_lanes.v2 ^ sbi_pkg::SIP_FINAL_XOR;
        end
        w_round_out = sbi_pkg::lane_round(w_round_in);
        if (i_ctrl.xor_v0) begin
            w_round_out.v0 = w_round_out.v0 ^ i_msg;
        end

        n_lanes = r_lanes;
        if (i_ctrl.init) begin
            n_lanes.v0 = sbi_pkg::LANE0_RESET;
            n_lanes.v1 = sbi_pkg::LANE1_RESET;
            n_lanes.v2 = sbi_pkg::LANE2_RESET;
            n_lanes.v3 = sbi_pkg::LANE3_RESET;
        end else if (i_ctrl.round) begin
            n_lanes = w_round_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes.v0 <= sbi_pkg::LANE0_RESET;
            r_lanes.v1 <= sbi_pkg::LANE1_RESET;
            r_lanes.v2 <= sbi_pkg::LANE2_RESET;
            r_lanes.v3 <= sbi_pkg::LANE3_RESET;
        end else begin
            r_lanes <= n_lanes;
        end
    end

    assign o_hash = r_lanes.v0 ^ r_lanes.v1 ^ r_lanes.v2 ^ r_lanes.v3;

endmodule

`default_nettype wire

// ----- hdl/sbi_mod_unit.sv -----
// Restoring 64 by 32 bit remainder unit, one quotient bit per cycle.
`default_nettype none

module sbi_mod_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_dividend,
    input  logic [31:0]          i_divisor,
    output sbi_pkg::t_mod_status o_status,
    output logic [31:0]          o_remainder
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_dvd;
    logic [31:0] r_div;
    logic [31:0] r_rem;
    logic        r_div_zero;
    logic [32:0] w_shifted;
    logic [32:0] w_diff;
    logic        w_fits;

    assign w_shifted = {r_rem, r_dvd[63]};
    assign w_diff    = w_shifted - {1'b0, r_div};
    assign w_fits    = (w_shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd      <= i_dividend;
            r_div      <= i_divisor;
            r_rem      <= '0;
            r_div_zero <= (i_divisor == 32'd0);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= w_fits ? w_diff[31:0] : w_shifted[31:0];
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_remainder   = r_div_zero ? 32'd0 : r_rem;

endmodule

`default_nettype wire
